// ===== rtl/rit_pkg.sv =====
// Shared types and constants for the record interpolation table.
`default_nettype none

package rit_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_W       = 9;
    localparam int REC_W       = 31;
    localparam int COEF_W      = 32;
    localparam int NCOEF       = 4;
    localparam int WGT_W       = 16;
    localparam int DIFF_W      = COEF_W + 1;
    localparam int PROD_W      = DIFF_W + WGT_W + 1;
    localparam int DIVCNT_W    = $clog2(WGT_W);
    localparam int BLCNT_W     = $clog2(NCOEF + 1);
    localparam int COEF_IDX_W  = $clog2(NCOEF);

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] STATUS_INTERP   = 2'd0;
    localparam logic [1:0] STATUS_CLAMP_LO = 2'd1;
    localparam logic [1:0] STATUS_CLAMP_HI = 2'd2;
    localparam logic [1:0] STATUS_EMPTY    = 2'd3;

    typedef struct packed {
        logic                     func;
        logic [7:0]               entry_index;
        logic [REC_W-1:0]         record_number;
        logic signed [COEF_W-1:0] in_draft;
        logic signed [COEF_W-1:0] in_surface_speed_error;
        logic signed [COEF_W-1:0] in_layer_depth;
        logic signed [COEF_W-1:0] in_layer_speed_error;
    } t_in_word;

    typedef struct packed {
        logic [REC_W-1:0]         result_record;
        logic signed [COEF_W-1:0] out_draft;
        logic signed [COEF_W-1:0] out_surface_speed_error;
        logic signed [COEF_W-1:0] out_layer_depth;
        logic signed [COEF_W-1:0] out_layer_speed_error;
        logic [1:0]               status;
    } t_out_word;

    // One table entry as held in memory; coefficient 0 is the draft, 3 the layer error.
    typedef struct packed {
        logic [REC_W-1:0]                rec;
        logic [NCOEF-1:0][COEF_W-1:0]    coef;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_WALK,
        S_DIV,
        S_BLEND,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/record_interpolation_table.sv =====
// Top level of the record interpolation table: entry memory, search sequencer,
// serial divider and blend unit.
//
// Usage. Input words arrive on i_in_valid / o_in_ready carrying t_in_word. A
// word with func set to write stores one entry (record number and four Q16.16
// coefficients) at entry_index and produces no result. A query word produces
// exactly one t_out_word on o_out_valid / i_out_ready. The user sets the number
// of entries in use through i_cfg_we / i_cfg_data while the block is idle, which
// the block does not enforce; counts above the table depth act as the full depth.
//
// Sequence. A query against an empty table goes straight to the done state, a
// clamped query ends once entry 0 or the last entry is read. An interpolated query
// reads entry 0, the last entry and then walks the table one entry per cycle
// through the single read port of the entry memory, then runs the restoring
// divider (one quotient bit a cycle) and the blend unit, which shares one
// multiplier across the four coefficients. One item is worked on at a time.
//
// Reset (synchronous, active low) clears the entry count and the handshake
// state only; the table contents are undefined until written. If the receiver
// stalls, the finished result sits in the output register and the block holds
// its next result until that register is free, accepting no further words.
`default_nettype none

module record_interpolation_table (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire rit_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output rit_pkg::t_out_word      o_out_word,
    input  wire logic               i_cfg_we,
    input  wire logic [rit_pkg::CFG_W-1:0] i_cfg_data
);
    import rit_pkg::*;

    // Control state.
    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_entry_count;
    logic                r_out_valid;
    t_out_word           r_out;

    // Entry memory with a registered read port.
    t_entry              r_mem [TABLE_DEPTH];
    t_entry              r_rd_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;

    // Query working registers.
    logic [REC_W-1:0]    r_rec;
    logic [ADDR_W-1:0]   r_last_idx;
    logic [ADDR_W-1:0]   r_idx;
    t_entry              r_prev;
    t_entry              r_post;
    logic [REC_W-1:0]    r_rem;
    logic [REC_W-1:0]    r_den;
    logic [WGT_W-1:0]    r_q;
    logic [DIVCNT_W-1:0] r_div_cnt;
    logic [BLCNT_W-1:0]  r_blend_cnt;
    logic signed [PROD_W-1:0] r_prod;

    // Result staging, moved to the output register in S_DONE.
    logic [REC_W-1:0]             r_res_rec;
    logic [NCOEF-1:0][COEF_W-1:0] r_res_coef;
    logic [1:0]                   r_res_status;

    logic                in_acc;
    logic                out_free;
    logic [CNT_W-1:0]    n_count;
    logic                walk_more;
    logic [REC_W:0]      div_shift;
    logic                div_sub;
    logic [COEF_IDX_W-1:0] k_mul;
    logic [COEF_IDX_W-1:0] k_add;
    logic signed [DIFF_W-1:0] blend_diff;
    logic signed [PROD_W-1:0] blend_prod;
    logic [COEF_W-1:0]   blend_res;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Entries in use, limited to the physical depth.
    assign n_count = (int'(r_entry_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                         : CNT_W'(r_entry_count);

    // The walk moves on while the entry just read is still below the query and is not the last entry.
    assign walk_more = (r_idx < r_last_idx) && (r_rec > r_rd_data.rec);

    // One restoring division step; the remainder stays below the divisor.
    assign div_shift = {r_rem, 1'b0};
    assign div_sub   = (div_shift >= {1'b0, r_den});

    // Blend: out = post + ((prev - post) * w) >>> 16, one coefficient a cycle.
    assign k_mul      = r_blend_cnt[COEF_IDX_W-1:0];
    assign k_add      = COEF_IDX_W'(r_blend_cnt - 1'b1);
    assign blend_diff = $signed({r_prev.coef[k_mul][COEF_W-1], r_prev.coef[k_mul]})
                      - $signed({r_post.coef[k_mul][COEF_W-1], r_post.coef[k_mul]});
    assign blend_prod = blend_diff * $signed({1'b0, r_q});
    assign blend_res  = r_post.coef[k_add] + r_prod[WGT_W +: COEF_W];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_word.func == FUNC_QUERY) begin
                    n_state = (n_count == '0) ? S_DONE : S_FIRST;
                end
            end
            S_FIRST: begin
                n_state = (r_rec <= r_rd_data.rec) ? S_DONE : S_LAST;
            end
            S_LAST: begin
                n_state = (r_rec >= r_rd_data.rec) ? S_DONE : S_WALK;
            end
            S_WALK: begin
                if (!walk_more) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_div_cnt == DIVCNT_W'(WGT_W - 1)) begin
                    n_state = S_BLEND;
                end
            end
            S_BLEND: begin
                if (r_blend_cnt == BLCNT_W'(NCOEF)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and memory port control. In S_IDLE the block
    // is always ready, so a valid word there is an accepted word.
    always_comb begin
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                rd_en      = i_in_valid && (i_in_word.func == FUNC_QUERY);
                wr_en      = i_in_valid && (i_in_word.func == FUNC_WRITE)
                          && (int'(i_in_word.entry_index) < TABLE_DEPTH);
            end
            S_FIRST: begin
                rd_en   = 1'b1;
                rd_addr = r_last_idx;
            end
            S_LAST: begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(1);
            end
            S_WALK: begin
                rd_en   = walk_more;
                rd_addr = r_idx + 1'b1;
            end
            S_DIV, S_BLEND, S_DONE: begin
                rd_en = 1'b0;
            end
            default: rd_en = 1'b0;
        endcase
    end

    // Entry memory.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[ADDR_W'(i_in_word.entry_index)] <= '{
                rec:  i_in_word.record_number,
                coef: {i_in_word.in_layer_speed_error, i_in_word.in_layer_depth,
                       i_in_word.in_surface_speed_error, i_in_word.in_draft}
            };
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Query datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_rec      <= i_in_word.record_number;
                r_last_idx <= ADDR_W'(n_count - 1'b1);
                r_idx      <= ADDR_W'(1);
                r_res_rec    <= '0;
                r_res_coef   <= '0;
                r_res_status <= STATUS_EMPTY;
            end
            S_FIRST: begin
                r_prev       <= r_rd_data;
                r_res_rec    <= r_rd_data.rec;
                r_res_coef   <= r_rd_data.coef;
                r_res_status <= STATUS_CLAMP_LO;
            end
            S_LAST: begin
                r_res_rec    <= r_rd_data.rec;
                r_res_coef   <= r_rd_data.coef;
                r_res_status <= STATUS_CLAMP_HI;
            end
            S_WALK: begin
                if (walk_more) begin
                    r_prev <= r_rd_data;
                    r_idx  <= r_idx + 1'b1;
                end else begin
                    r_post      <= r_rd_data;
                    r_rem       <= r_rd_data.rec - r_rec;
                    r_den       <= r_rd_data.rec - r_prev.rec;
                    r_div_cnt   <= '0;
                    r_q         <= '0;
                end
            end
            S_DIV: begin
                r_rem       <= div_sub ? REC_W'(div_shift - {1'b0, r_den})
                                       : REC_W'(div_shift);
                r_q         <= {r_q[WGT_W-2:0], div_sub};
                r_div_cnt   <= r_div_cnt + 1'b1;
                r_blend_cnt <= '0;
            end
            S_BLEND: begin
                if (r_blend_cnt < BLCNT_W'(NCOEF)) begin
                    r_prod <= blend_prod;
                end
                if (r_blend_cnt != '0) begin
                    r_res_coef[k_add] <= blend_res;
                end
                r_blend_cnt  <= r_blend_cnt + 1'b1;
                r_res_rec    <= r_rec;
                r_res_status <= STATUS_INTERP;
            end
            default: begin
            end
        endcase
        if (r_state == S_DONE && out_free) begin
            r_out <= '{
                result_record:           r_res_rec,
                out_draft:               r_res_coef[0],
                out_surface_speed_error: r_res_coef[1],
                out_layer_depth:         r_res_coef[2],
                out_layer_speed_error:   r_res_coef[3],
                status:                  r_res_status
            };
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // The divider remainder must stay below the divisor, else the weight overflows.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    // The walk never passes the last entry in use.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_idx <= r_last_idx))
        else $error("walk index beyond last entry");

    // A finished query always lands in the output register.
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished query did not reach the output register");

    // An accepted query always leaves the idle state.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.func == FUNC_QUERY) |=> (r_state != S_IDLE))
        else $error("accepted query was dropped");

    // A write word never starts a search.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.func == FUNC_WRITE) |=> (r_state == S_IDLE))
        else $error("write word started a search");

endmodule

`default_nettype wire
